// File: hdl/assert_macros.svh
// assert_macros.svh: concurrent assertion shorthands used by bst_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bst_pkg.sv
// ---------------------------------------------------------------------------
// bst_pkg: shared types and constants of the barrier table
// Table size, cell chain link, command broadcast and opcode/state codes.
// ---------------------------------------------------------------------------
package bst_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BIDX_W  = 4;
  localparam int CMP_W   = (IDX_W > BIDX_W) ? IDX_W : BIDX_W;

  localparam logic [15:0]       COUNT_MAX = 16'hFFFF;
  localparam logic [7:0]        REFS_MAX  = 8'hFF;
  localparam logic signed [4:0] IDX_FULL  = 5'sh1F;  // -1: no entry available

  typedef enum logic [1:0] {
    OP_OPEN    = 2'd0,
    OP_ARRIVE  = 2'd1,
    OP_DESTROY = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } st_t;

  // travels cell to cell along the row
  typedef struct packed {
    logic             match_seen;
    logic [IDX_W-1:0] match_idx;
    logic             free_seen;
    logic [IDX_W-1:0] free_idx;
    logic             arr_hit;
    logic [15:0]      arr_count;
    logic             arr_rel;
  } chain_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               commit;
    logic [1:0]         op;
    logic signed [31:0] key;
    logic [15:0]        goal;
    logic [BIDX_W-1:0]  idx;
  } cmd_t;

  function automatic logic signed [4:0] out_index(input logic [IDX_W-1:0] i);
    logic [8:0] w;
    w = 9'(i);
    return w[4:0];
  endfunction

endpackage

// File: hdl/bst_ifs.sv
// ---------------------------------------------------------------------------
// bst_ifs: valid/ready channels of the barrier table
// Request channel and result channel, each with source and sink views.
// ---------------------------------------------------------------------------
interface bst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] barrier_key;
  logic [15:0]        arrival_goal;
  logic [3:0]         barrier_index;

  modport source (output valid, opcode, barrier_key, arrival_goal, barrier_index,
                  input ready);
  modport sink   (input valid, opcode, barrier_key, arrival_goal, barrier_index,
                  output ready);
endinterface

interface bst_out_if;
  logic              valid;
  logic              ready;
  logic signed [4:0] entry_index;
  logic              released;
  logic [15:0]       arrivals_now;

  modport source (output valid, entry_index, released, arrivals_now, input ready);
  modport sink   (input valid, entry_index, released, arrivals_now, output ready);
endinterface

// File: hdl/bst_cell.sv
// ---------------------------------------------------------------------------
// bst_cell: one barrier entry
// Holds key, goal, count and refs; folds its lookup flags and arrive result
// into the chain word from its left neighbor.
// ---------------------------------------------------------------------------
module bst_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bst_pkg::IDX_W-1:0] cell_idx,
  input  bst_pkg::cmd_t             cmd,
  input  logic                      win_valid,
  input  logic [bst_pkg::IDX_W-1:0] win_idx,
  input  bst_pkg::chain_t           chain_in,
  output bst_pkg::chain_t           chain_out
);
  import bst_pkg::*;

  logic signed [31:0] key_r, key_nxt;
  logic [15:0]        goal_r, goal_nxt;
  logic [15:0]        count_r, count_nxt;
  logic [7:0]         refs_r, refs_nxt;

  logic        alloc, hit, sel, won, rel;
  logic [15:0] cnt_inc;

  assign alloc   = (refs_r != 8'd0);
  assign hit     = alloc && (key_r == cmd.key);
  assign sel     = (CMP_W'(cmd.idx) == CMP_W'(cell_idx));
  assign won     = win_valid && (win_idx == cell_idx);
  assign cnt_inc = (count_r != COUNT_MAX) ? count_r + 16'd1 : count_r;
  assign rel     = (cnt_inc >= goal_r);

  always_comb begin
    chain_out            = chain_in;
    chain_out.match_seen = chain_in.match_seen | hit;
    chain_out.match_idx  = chain_in.match_seen ? chain_in.match_idx : cell_idx;
    chain_out.free_seen  = chain_in.free_seen | !alloc;
    chain_out.free_idx   = chain_in.free_seen ? chain_in.free_idx : cell_idx;
    if (sel) begin
      chain_out.arr_hit   = 1'b1;
      chain_out.arr_count = cnt_inc;
      chain_out.arr_rel   = rel;
    end
  end

  always_comb begin
    key_nxt   = key_r;
    goal_nxt  = goal_r;
    count_nxt = count_r;
    refs_nxt  = refs_r;
    if (cmd.commit) begin
      case (cmd.op)
        OP_OPEN: begin
          if (won) begin
            key_nxt  = cmd.key;
            goal_nxt = cmd.goal;
            if (refs_r != REFS_MAX) refs_nxt = refs_r + 8'd1;
          end
        end
        OP_ARRIVE: begin
          if (sel) count_nxt = rel ? 16'd0 : cnt_inc;
        end
        OP_DESTROY: begin
          if (sel) begin
            refs_nxt  = 8'd0;
            goal_nxt  = 16'd0;
            count_nxt = 16'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r  <= '0;
      count_r <= '0;
      refs_r  <= '0;
    end else begin
      goal_r  <= goal_nxt;
      count_r <= count_nxt;
      refs_r  <= refs_nxt;
    end
  end

  // key only ever compared while refs is nonzero, so it needs no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// File: hdl/barrier_sync_table.sv
// ---------------------------------------------------------------------------
// barrier_sync_table: table of counting barriers
// A row of entry cells with a two-state controller and a result register.
//
//   channel | dir | word
//   --------+-----+---------------------------------------------------------
//   in_ch   | in  | opcode, barrier_key, arrival_goal, barrier_index
//   out_ch  | out | entry_index, released, arrivals_now
//
// Each word is latched into the request registers in ST_IDLE; in ST_EXEC the key lookup
// ripples along the cell row and the entry is updated.
// One request in flight; the next is taken while a result waits in the
// output register, and the update stalls until that register is free.
// Synchronous active-low reset frees every entry at once; no clearing pass.
// ---------------------------------------------------------------------------
module barrier_sync_table (
  input logic         clk,
  input logic         rst_n,
  bst_in_if.sink      in_ch,
  bst_out_if.source   out_ch
);
  import bst_pkg::*;

  st_t state_r, state_nxt;

  logic [1:0]         op_r;
  logic signed [31:0] key_r;
  logic [15:0]        goal_r;
  logic [BIDX_W-1:0]  idx_r;

  logic              out_valid_r, out_valid_nxt;
  logic signed [4:0] entry_index_r, entry_index_nxt;
  logic              released_r, released_nxt;
  logic [15:0]       arrivals_r, arrivals_nxt;

  logic             in_acc, commit;
  logic             win_valid;
  logic [IDX_W-1:0] win_idx;
  cmd_t             cmd;
  chain_t           link [ENTRIES+1];

  assign in_acc = in_ch.valid && in_ch.ready;
  assign commit = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_EXEC: in_ch.ready = 1'b0;
      default: in_ch.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_ch.opcode;
      key_r <= in_ch.barrier_key;
      goal_r <= in_ch.arrival_goal;
      idx_r <= in_ch.barrier_index;
    end
  end

  always_comb begin
    cmd.commit = commit;
    cmd.op     = op_r;
    cmd.key    = key_r;
    cmd.goal   = goal_r;
    cmd.idx    = idx_r;
  end

  // match beats free; both chosen at the lowest index by the ripple
  assign win_valid = link[ENTRIES].match_seen || link[ENTRIES].free_seen;
  assign win_idx   = link[ENTRIES].match_seen ? link[ENTRIES].match_idx
                                              : link[ENTRIES].free_idx;

  assign link[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .cmd       (cmd),
      .win_valid (win_valid),
      .win_idx   (win_idx),
      .chain_in  (link[g]),
      .chain_out (link[g+1])
    );
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    entry_index_nxt = entry_index_r;
    released_nxt    = released_r;
    arrivals_nxt    = arrivals_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (commit) begin
      out_valid_nxt   = 1'b1;
      entry_index_nxt = 5'sd0;
      released_nxt    = 1'b0;
      arrivals_nxt    = 16'd0;
      case (op_r)
        OP_OPEN: entry_index_nxt = win_valid ? out_index(win_idx) : IDX_FULL;
        OP_ARRIVE: begin
          // out-of-range index selects no cell and reports zeros
          if (link[ENTRIES].arr_hit) begin
            released_nxt = link[ENTRIES].arr_rel;
            arrivals_nxt = link[ENTRIES].arr_count;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    entry_index_r <= entry_index_nxt;
    released_r    <= released_nxt;
    arrivals_r    <= arrivals_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.entry_index  = entry_index_r;
  assign out_ch.released     = released_r;
  assign out_ch.arrivals_now = arrivals_r;

endmodule

// File: hdl/bst_checker.sv
// ---------------------------------------------------------------------------
// bst_checker: port-level checks of the barrier table
// Watches both channels and is bound onto the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bst_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [4:0] out_entry_index,
  input logic              out_released,
  input logic [15:0]       out_arrivals_now
);

  `BST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_entry_index) && $stable(out_released) && $stable(out_arrivals_now), "result word changed while stalled")

  `BST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while one is in flight")

  `BST_ASSERT_IMP(a_result_after_work, clk, rst_n, $rose(out_valid), !$past(in_ready), "result appeared without a request in work")

  `BST_ASSERT_IMP(a_arrive_fields, clk, rst_n, out_valid && (out_released || out_arrivals_now != 16'd0), out_entry_index == 5'sd0, "arrive result carries an entry index")

endmodule

bind barrier_sync_table bst_checker u_bst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_entry_index  (out_ch.entry_index),
  .out_released     (out_ch.released),
  .out_arrivals_now (out_ch.arrivals_now)
);

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for barrier_sync_table
// Drives open, arrive, destroy and unused-opcode words with random gaps and output stalls,
// predicts each result from a shadow copy of the barrier table and compares
// every result word field by field, in order.
// ---------------------------------------------------------------------------
module testbench;
  import bst_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         HOLD_CYCLES = 200;
  localparam int         POOL_SIZE   = 24;

  typedef struct packed {
    logic signed [4:0] entry_index;
    logic              released;
    logic [15:0]       arrivals_now;
  } barrier_result_t;

  logic clk;
  logic rst_n;

  bst_in_if  in_ch ();
  bst_out_if out_ch ();

  barrier_sync_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the barrier table
  logic signed [31:0] shadow_key   [ENTRIES];
  logic [15:0]        shadow_goal  [ENTRIES];
  logic [15:0]        shadow_count [ENTRIES];
  logic [7:0]         shadow_refs  [ENTRIES];

  barrier_result_t    pending_results[$];
  logic signed [31:0] key_pool [POOL_SIZE];
  int                 err_count;
  int                 cycle_count;
  logic               quiet;
  logic               hold_tgl;

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- table predictor ----------------------------------------------------
  function automatic barrier_result_t barrier_apply(input logic [1:0] op,
                                                    input logic signed [31:0] key,
                                                    input logic [15:0] goal,
                                                    input logic [3:0] idx);
    barrier_result_t r;
    int              pick;
    logic [16:0]     c;
    r    = '0;
    pick = -1;
    case (op)
      OP_OPEN: begin
        // a live key match beats any free slot
        for (int i = 0; i < ENTRIES; i++)
          if (pick < 0 && shadow_refs[i] != 8'd0 && shadow_key[i] == key) pick = i;
        for (int i = 0; i < ENTRIES; i++)
          if (pick < 0 && shadow_refs[i] == 8'd0) pick = i;
        if (pick < 0) begin
          r.entry_index = IDX_FULL;
        end else begin
          if (shadow_refs[pick] != REFS_MAX) shadow_refs[pick] = shadow_refs[pick] + 8'd1;
          shadow_key[pick]  = key;
          shadow_goal[pick] = goal;
          r.entry_index     = 5'(pick);
        end
      end
      OP_ARRIVE: begin
        if (int'(idx) < ENTRIES) begin
          c = {1'b0, shadow_count[idx]};
          if (c < {1'b0, COUNT_MAX}) c = c + 17'd1;
          r.arrivals_now = c[15:0];
          if (c >= {1'b0, shadow_goal[idx]}) begin
            r.released        = 1'b1;
            shadow_count[idx] = 16'd0;
          end else begin
            shadow_count[idx] = c[15:0];
          end
        end
      end
      OP_DESTROY: begin
        if (int'(idx) < ENTRIES) begin
          shadow_refs[idx]  = 8'd0;
          shadow_goal[idx]  = 16'd0;
          shadow_count[idx] = 16'd0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] pick_live_entry();
    int live[$];
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_refs[i] != 8'd0) live.push_back(i);
    if (live.size() == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, ENTRIES - 1));
    return 4'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  // ---- result checker -----------------------------------------------------
  always @(posedge clk) begin : check_results
    barrier_result_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: expected none, got index %0d released %0b arrivals %0d",
                 $time, out_ch.entry_index, out_ch.released, out_ch.arrivals_now);
        err_count++;
      end else begin
        exp = pending_results.pop_front();
        if (out_ch.entry_index !== exp.entry_index) begin
          $display("%0t: entry_index expected %0d got %0d",
                   $time, exp.entry_index, out_ch.entry_index);
          err_count++;
        end
        if (out_ch.released !== exp.released) begin
          $display("%0t: released expected %0b got %0b", $time, exp.released, out_ch.released);
          err_count++;
        end
        if (out_ch.arrivals_now !== exp.arrivals_now) begin
          $display("%0t: arrivals_now expected %0d got %0d",
                   $time, exp.arrivals_now, out_ch.arrivals_now);
          err_count++;
        end
      end
    end
  end

  // ---- result sink: random stalls plus one long hold on request -----------
  initial begin : result_sink
    logic seen_tgl;
    int   burst;
    out_ch.ready = 1'b0;
    seen_tgl     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tgl != seen_tgl) begin
        seen_tgl = hold_tgl;
        out_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---- request side -------------------------------------------------------
  // valid stays high from word to word; it drops only in a gap or a drain
  task automatic send_word(input logic [1:0] op, input logic signed [31:0] key,
                           input logic [15:0] goal, input logic [3:0] idx);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.barrier_key   <= key;
    in_ch.arrival_goal  <= goal;
    in_ch.barrier_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(barrier_apply(op, key, goal, idx));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed traffic: pooled keys, small goals, arrivals at live entries
  task automatic send_random_word();
    int                 pct;
    logic signed [31:0] key;
    logic [15:0]        goal;
    pct  = $urandom_range(0, 99);
    key  = $urandom;
    goal = 16'($urandom);
    if (pct < 38) begin
      if ($urandom_range(0, 9) != 0) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 9))
        0, 1:    goal = 16'($urandom);
        2:       goal = ($urandom_range(0, 1) != 0) ? COUNT_MAX : 16'd0;
        default: goal = 16'($urandom_range(0, 5));
      endcase
      send_word(OP_OPEN, key, goal, 4'($urandom));
    end else if (pct < 82) begin
      send_word(OP_ARRIVE, key, goal, pick_live_entry());
    end else if (pct < 96) begin
      send_word(OP_DESTROY, key, goal, pick_live_entry());
    end else begin
      send_word(OP_UNUSED, key, goal, 4'($urandom));
    end
  endtask

  // ---- tests --------------------------------------------------------------
  // arrive at a free entry (goal zero after reset), unused opcode, destroy of a free entry
  task automatic test_idle_table();
    send_word(OP_ARRIVE, $urandom, 16'($urandom), 4'd3);
    send_word(OP_UNUSED, 32'sh7FFF_FFFF, 16'hFFFF, 4'hF);
    send_word(OP_DESTROY, $urandom, 16'($urandom), 4'd15);
    drain();
  endtask

  // fill every entry, then one open too many, then an open of a live key while full
  task automatic test_fill_table();
    logic signed [31:0] key;
    for (int i = 0; i < ENTRIES; i++) begin
      case (i)
        0:       key = 32'sh8000_0000;
        1:       key = 32'sh7FFF_FFFF;
        2:       key = 32'sh0;
        3:       key = -32'sd1;
        default: key = $signed(32'h0101_0101 * i);
      endcase
      send_word(OP_OPEN, key, (i == 0) ? COUNT_MAX : 16'(i - 1), 4'(i));
    end
    send_word(OP_OPEN, 32'sh1234_5678, 16'd7, 4'd0);
    send_word(OP_OPEN, -32'sd1, 16'd2, 4'd0);
    drain();
  endtask

  // wait then release; reopen with a goal equal to the current count
  task automatic test_arrive_release();
    send_word(OP_ARRIVE, $urandom, 16'($urandom), 4'd3);
    send_word(OP_ARRIVE, $urandom, 16'($urandom), 4'd3);
    send_word(OP_ARRIVE, $urandom, 16'($urandom), 4'd0);
    send_word(OP_OPEN, 32'sh8000_0000, 16'd1, 4'd0);
    send_word(OP_ARRIVE, $urandom, 16'($urandom), 4'd0);
    send_word(OP_ARRIVE, $urandom, 16'($urandom), 4'd15);
    drain();
  endtask

  // a live match at a high index wins over a lower free entry
  task automatic test_key_precedence();
    send_word(OP_DESTROY, $urandom, 16'($urandom), 4'd3);
    send_word(OP_OPEN, $signed(32'h0101_0101 * 9), 16'd4, 4'd0);
    send_word(OP_OPEN, 32'sh0BAD_F00D, 16'd3, 4'd0);
    drain();
  endtask

  // reference count must stick at its maximum, not wrap to free
  task automatic test_ref_saturation();
    logic signed [31:0] key;
    key = $urandom;
    send_word(OP_DESTROY, $urandom, 16'($urandom), 4'd5);
    for (int n = 0; n < 260; n++) send_word(OP_OPEN, key, 16'($urandom), 4'($urandom));
    send_word(OP_OPEN, ~key, 16'd1, 4'd0);
    send_word(OP_DESTROY, $urandom, 16'($urandom), 4'd5);
    send_word(OP_OPEN, key ^ 32'sh0000_00FF, 16'd1, 4'd0);
    drain();
  endtask

  task automatic test_random(input int n_words);
    for (int n = 0; n < n_words; n++) send_random_word();
    drain();
  endtask

  // long output hold while words keep coming: the input has to stall
  task automatic test_backpressure();
    hold_tgl <= ~hold_tgl;
    for (int n = 0; n < 24; n++) send_random_word();
    drain();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_OPEN;
    in_ch.barrier_key   = '0;
    in_ch.arrival_goal  = '0;
    in_ch.barrier_index = '0;
    quiet               = 1'b0;
    hold_tgl            = 1'b0;
    err_count           = 0;
    cycle_count         = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i]   = '0;
      shadow_goal[i]  = '0;
      shadow_count[i] = '0;
      shadow_refs[i]  = '0;
    end
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_table();
    test_fill_table();
    test_arrive_release();
    test_key_precedence();
    test_ref_saturation();
    test_random(200);
    test_backpressure();
    test_random(130);
    quiet = 1'b1;
    test_random(100);

    repeat (20) @(posedge clk);  // catch late or extra words
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
